FILE: rtl/jdsp_pkg.sv
// Package for the joystick dual servo pulse generator.
// Holds widths, reset values, codes and the structs shared by the lanes, core and top.
// No dependencies.
package jdsp_pkg;

  // Converter reading width and derived widths
  localparam int SAMPLE_BITS = 10;
  localparam int CMP_W       = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
  localparam int DIST_W      = SAMPLE_BITS;
  localparam int HALF_W      = 7;
  localparam int PROD_W      = DIST_W + HALF_W;

  // Step divisor 4608 = 9 * 512: shift by 9, then divide by 9 via reciprocal
  localparam int DIV_SHIFT   = 9;
  localparam int DIV_ODD     = 9;
  localparam int Q_W         = PROD_W - DIV_SHIFT;
  localparam int RCP_SHIFT   = Q_W + 4;
  localparam int RCP_MUL     = ((1 << RCP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
  localparam int RCP_W       = RCP_SHIFT - 2;
  localparam int STEP_W      = Q_W - 3;
  localparam int SUM_W       = ((STEP_W > 8) ? STEP_W : 8) + 1;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LAST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_SEC  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SEC   = 3'd7;

  // Beat operation codes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Reset values
  localparam logic [9:0]  DEAD_LOW_RST  = 10'd500;
  localparam logic [9:0]  DEAD_HIGH_RST = 10'd524;
  localparam logic [7:0]  WIDTH_MIN_RST = 8'd25;
  localparam logic [7:0]  WIDTH_MAX_RST = 8'd87;
  localparam logic [7:0]  SLOT_LAST_RST = 8'd38;
  localparam logic [4:0]  SLOTS_RST     = 5'd20;
  localparam logic [15:0] TICKS_SEC_RST = 16'd37500;
  localparam logic [7:0]  HOLD_SEC_RST  = 8'd5;
  localparam logic [7:0]  WIDTH_RST     = 8'd57;
  localparam logic [7:0]  SECONDS_MAX   = 8'd255;

  typedef struct packed {
    logic [9:0]  dead_low;
    logic [9:0]  dead_high;
    logic [7:0]  width_min;
    logic [7:0]  width_max;
    logic [7:0]  slot_last;
    logic [4:0]  slots_per_frame;
    logic [15:0] ticks_per_second;
    logic [7:0]  hold_seconds;
  } cfg_t;

  // What one axis lane found for a sample beat
  typedef struct packed {
    logic              up;
    logic              down;
    logic [STEP_W-1:0] step;
  } lane_res_t;

  typedef struct packed {
    logic       drive_x;
    logic       drive_y;
    logic [7:0] x_width;
    logic [7:0] y_width;
    logic       frozen;
  } res_t;

endpackage

FILE: rtl/jdsp_if.sv
// Valid/ready channel interfaces for the servo pulse generator.
// Depends on jdsp_pkg for the sample width.
interface jdsp_in_if;
  import jdsp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;
  logic                   button;

  modport source (output valid, output op, output x_sample, output y_sample,
                  output button, input ready);
  modport sink   (input valid, input op, input x_sample, input y_sample,
                  input button, output ready);
endinterface

interface jdsp_out_if;
  logic       valid;
  logic       ready;
  logic       drive_x;
  logic       drive_y;
  logic [7:0] x_width;
  logic [7:0] y_width;
  logic       frozen;

  modport source (output valid, output drive_x, output drive_y, output x_width,
                  output y_width, output frozen, input ready);
  modport sink   (input valid, input drive_x, input drive_y, input x_width,
                  input y_width, input frozen, output ready);
endinterface

FILE: rtl/jdsp_lane.sv
// One axis lane: dead band test and step size for a joystick reading.
// Two register stages (product, then divide by 4608). Depends on jdsp_pkg.
module jdsp_lane (
  input  logic                             clk,
  input  logic                             ld_a,
  input  logic                             ld_b,
  input  logic [jdsp_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [9:0]                       dead_low,
  input  logic [9:0]                       dead_high,
  input  logic [jdsp_pkg::HALF_W-1:0]      half,
  output jdsp_pkg::lane_res_t              res
);
  import jdsp_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] MID = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

  logic              up_a_r, down_a_r;
  logic [PROD_W-1:0] prod_a_r;
  logic [DIST_W-1:0] dist_mid;
  logic              up, down;
  logic [Q_W-1:0]    quot;
  logic [Q_W+RCP_W-1:0] scaled;
  lane_res_t         res_r, res_nxt;

  // Stage A: distance from mid scale, dead band flags, product with half span
  always_comb begin
    dist_mid = sample[SAMPLE_BITS-1] ? (sample - MID) : (MID - sample);
    up       = CMP_W'(sample) < CMP_W'(dead_low);
    down     = !up && (CMP_W'(sample) > CMP_W'(dead_high));
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      up_a_r   <= up;
      down_a_r <= down;
      prod_a_r <= PROD_W'(dist_mid) * PROD_W'(half);
    end
  end

  // Stage B: drop the power-of-two part, divide the rest by 9 via reciprocal
  always_comb begin
    quot         = prod_a_r[PROD_W-1:DIV_SHIFT];
    scaled       = (Q_W+RCP_W)'(quot) * (Q_W+RCP_W)'(RCP_MUL);
    res_nxt.up   = up_a_r;
    res_nxt.down = down_a_r;
    res_nxt.step = scaled[RCP_SHIFT +: STEP_W];
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/jdsp_core.sv
// Merge stage: frame timing, width update from both lanes, button freeze logic.
// Holds the frame, width and button state and the result register. Depends on jdsp_pkg.
module jdsp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                op,
  input  logic                button,
  input  jdsp_pkg::lane_res_t lane_x,
  input  jdsp_pkg::lane_res_t lane_y,
  input  jdsp_pkg::cfg_t      cfg,
  output jdsp_pkg::res_t      res
);
  import jdsp_pkg::*;

  logic        first_r, first_nxt;
  logic        x_fallen_r, x_fallen_nxt, y_fallen_r, y_fallen_nxt;
  logic [7:0]  edge_r, edge_nxt;
  logic [7:0]  slot_tick_r, slot_tick_nxt;
  logic [4:0]  slot_idx_r, slot_idx_nxt;
  logic        pin_x_r, pin_x_nxt, pin_y_r, pin_y_nxt;
  logic [7:0]  width_x_r, width_x_nxt, width_y_r, width_y_nxt;
  logic        key_r, key_nxt;
  logic        timing_r, timing_nxt;
  logic [15:0] sub_sec_r, sub_sec_nxt;
  logic [7:0]  seconds_r, seconds_nxt;
  logic        stop_r, stop_nxt;
  res_t        res_r, res_nxt;

  // Nudge one width by the lane step, only if it stays inside the limits
  function automatic logic [7:0] adjust(input logic [7:0] w, input lane_res_t l,
                                        input logic [7:0] wmin, input logic [7:0] wmax);
    logic [SUM_W-1:0] ws, st, sum, dif;
    logic [7:0]       r;
    ws  = SUM_W'(w);
    st  = SUM_W'(l.step);
    sum = ws + st;
    dif = ws - st;
    r   = w;
    if (l.up) begin
      if (sum <= SUM_W'(wmax)) r = sum[7:0];
    end else if (l.down) begin
      if ((st <= ws) && (dif >= SUM_W'(wmin))) r = dif[7:0];
    end
    return r;
  endfunction

  // Next state for one beat
  always_comb begin
    first_nxt    = first_r;
    x_fallen_nxt = x_fallen_r;
    y_fallen_nxt = y_fallen_r;
    edge_nxt     = edge_r;
    slot_tick_nxt = slot_tick_r;
    slot_idx_nxt = slot_idx_r;
    pin_x_nxt    = pin_x_r;
    pin_y_nxt    = pin_y_r;
    width_x_nxt  = width_x_r;
    width_y_nxt  = width_y_r;
    key_nxt      = key_r;
    timing_nxt   = timing_r;
    sub_sec_nxt  = sub_sec_r;
    seconds_nxt  = seconds_r;
    stop_nxt     = stop_r;

    if (op == OP_TICK) begin
      // First frame starts on the first tick
      if (first_r) begin
        pin_x_nxt = 1'b1;
        pin_y_nxt = 1'b1;
        first_nxt = 1'b0;
      end
      if ((edge_r >= width_x_r) && !x_fallen_r) begin
        pin_x_nxt    = 1'b0;
        x_fallen_nxt = 1'b1;
      end
      if ((edge_r >= width_y_r) && !y_fallen_r) begin
        pin_y_nxt    = 1'b0;
        y_fallen_nxt = 1'b1;
      end
      edge_nxt = edge_r + 8'd1;
      // Slot counters
      if (slot_tick_r >= cfg.slot_last) begin
        slot_tick_nxt = '0;
        slot_idx_nxt  = slot_idx_r + 5'd1;
      end else begin
        slot_tick_nxt = slot_tick_r + 8'd1;
      end
      // Frame restart
      if (slot_idx_nxt >= cfg.slots_per_frame) begin
        slot_idx_nxt  = '0;
        pin_x_nxt     = 1'b1;
        pin_y_nxt     = 1'b1;
        x_fallen_nxt  = 1'b0;
        y_fallen_nxt  = 1'b0;
        edge_nxt      = '0;
        slot_tick_nxt = '0;
      end
      // Hold timer after button release
      if (timing_r) begin
        sub_sec_nxt = sub_sec_r + 16'd1;
        if (sub_sec_nxt >= cfg.ticks_per_second) begin
          sub_sec_nxt = '0;
          if (seconds_r < SECONDS_MAX) seconds_nxt = seconds_r + 8'd1;
        end
      end
    end else begin
      // Button press / release tracking
      if (button && !key_r && !timing_r) key_nxt = 1'b1;
      if (!button && key_nxt) begin
        key_nxt     = 1'b0;
        sub_sec_nxt = '0;
        seconds_nxt = '0;
        timing_nxt  = 1'b1;
      end
      if (!stop_r) begin
        width_x_nxt = adjust(width_x_r, lane_x, cfg.width_min, cfg.width_max);
        width_y_nxt = adjust(width_y_r, lane_y, cfg.width_min, cfg.width_max);
      end
      // Unfreeze at once, or freeze once the hold time has run out
      if (timing_nxt && (stop_r || (seconds_nxt >= cfg.hold_seconds))) begin
        stop_nxt   = !stop_r;
        timing_nxt = 1'b0;
      end
    end

    res_nxt.drive_x = pin_x_nxt;
    res_nxt.drive_y = pin_y_nxt;
    res_nxt.x_width = width_x_nxt;
    res_nxt.y_width = width_y_nxt;
    res_nxt.frozen  = stop_nxt;
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      x_fallen_r  <= 1'b0;
      y_fallen_r  <= 1'b0;
      edge_r      <= '0;
      slot_tick_r <= '0;
      slot_idx_r  <= '0;
      pin_x_r     <= 1'b0;
      pin_y_r     <= 1'b0;
      width_x_r   <= WIDTH_RST;
      width_y_r   <= WIDTH_RST;
      key_r       <= 1'b0;
      timing_r    <= 1'b0;
      sub_sec_r   <= '0;
      seconds_r   <= '0;
      stop_r      <= 1'b0;
      res_r       <= '{drive_x: 1'b0, drive_y: 1'b0, x_width: WIDTH_RST,
                       y_width: WIDTH_RST, frozen: 1'b0};
    end else if (load) begin
      first_r     <= first_nxt;
      x_fallen_r  <= x_fallen_nxt;
      y_fallen_r  <= y_fallen_nxt;
      edge_r      <= edge_nxt;
      slot_tick_r <= slot_tick_nxt;
      slot_idx_r  <= slot_idx_nxt;
      pin_x_r     <= pin_x_nxt;
      pin_y_r     <= pin_y_nxt;
      width_x_r   <= width_x_nxt;
      width_y_r   <= width_y_nxt;
      key_r       <= key_nxt;
      timing_r    <= timing_nxt;
      sub_sec_r   <= sub_sec_nxt;
      seconds_r   <= seconds_nxt;
      stop_r      <= stop_nxt;
      res_r       <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/joystick_dual_servo_pulse_generator.sv
// Joystick dual servo pulse generator, top level.
// Pipeline control, configuration registers, two axis lanes and the merge core.
// Depends on jdsp_pkg, jdsp_if, jdsp_lane, jdsp_core.
//
// Usage:
//   in_ch carries tick beats (op = 0) and joystick sample beats (op = 1, with
//   x/y readings and the button level). out_ch returns one result beat per
//   input beat, in order: both pin levels, both widths and the frozen flag as
//   they stand after that beat.
//   cfg_we/cfg_index/cfg_data write one register per cycle; write only while
//   no beats are in flight.
//   The three stages (lane product, lane divide, merge/output) each hold one
//   beat, so one beat is taken per cycle while out_ch keeps up.
//   When out_ch stalls, beats pile up in the free stages; in_ch.ready drops
//   once all three are full. A waiting result never blocks a new beat from
//   entering an empty stage.
//   Reset (rst_n low, synchronous) restores the configuration registers to their defaults,
//   empties the pipeline, sets both widths to 57 and pins low.
module joystick_dual_servo_pulse_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  jdsp_in_if.sink                        in_ch,
  jdsp_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [jdsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jdsp_pkg::CFG_W-1:0]     cfg_data
);
  import jdsp_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  logic [HALF_W-1:0] half;
  logic [7:0]        span;
  logic              v_a_r, v_b_r, out_valid_r;
  logic              op_a_r, op_b_r, btn_a_r, btn_b_r;
  logic              out_adv, b_fire, ld_b, ld_a, in_fire;
  lane_res_t         lane_x, lane_y;
  res_t              res;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEAD_LOW:  cfg_nxt.dead_low         = cfg_data[9:0];
        CFG_DEAD_HIGH: cfg_nxt.dead_high        = cfg_data[9:0];
        CFG_WIDTH_MIN: cfg_nxt.width_min        = cfg_data[7:0];
        CFG_WIDTH_MAX: cfg_nxt.width_max        = cfg_data[7:0];
        CFG_SLOT_LAST: cfg_nxt.slot_last        = cfg_data[7:0];
        CFG_SLOTS:     cfg_nxt.slots_per_frame  = cfg_data[4:0];
        CFG_TICKS_SEC: cfg_nxt.ticks_per_second = cfg_data[15:0];
        CFG_HOLD_SEC:  cfg_nxt.hold_seconds     = cfg_data[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dead_low: DEAD_LOW_RST, dead_high: DEAD_HIGH_RST,
                 width_min: WIDTH_MIN_RST, width_max: WIDTH_MAX_RST,
                 slot_last: SLOT_LAST_RST, slots_per_frame: SLOTS_RST,
                 ticks_per_second: TICKS_SEC_RST, hold_seconds: HOLD_SEC_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Half of the width span, zero when the limits are inverted
  always_comb begin
    span = cfg_r.width_max - cfg_r.width_min;
    half = (cfg_r.width_max >= cfg_r.width_min) ? span[7:1] : '0;
  end

  // Pipeline flow: each stage loads when empty or when its beat moves on
  always_comb begin
    out_adv = !out_valid_r || out_ch.ready;
    b_fire  = v_b_r && out_adv;
    ld_b    = !v_b_r || b_fire;
    ld_a    = !v_a_r || ld_b;
    in_fire = in_ch.valid && ld_a;
  end

  assign in_ch.ready = ld_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld_a) v_a_r <= in_fire;
      if (ld_b) v_b_r <= v_a_r;
      if (b_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Beat side fields travel alongside the lanes
  always_ff @(posedge clk) begin
    if (ld_a) begin
      op_a_r  <= in_ch.op;
      btn_a_r <= in_ch.button;
    end
    if (ld_b) begin
      op_b_r  <= op_a_r;
      btn_b_r <= btn_a_r;
    end
  end

  jdsp_lane u_lane_x (
    .clk       (clk),
    .ld_a      (ld_a),
    .ld_b      (ld_b),
    .sample    (in_ch.x_sample),
    .dead_low  (cfg_r.dead_low),
    .dead_high (cfg_r.dead_high),
    .half      (half),
    .res       (lane_x)
  );

  jdsp_lane u_lane_y (
    .clk       (clk),
    .ld_a      (ld_a),
    .ld_b      (ld_b),
    .sample    (in_ch.y_sample),
    .dead_low  (cfg_r.dead_low),
    .dead_high (cfg_r.dead_high),
    .half      (half),
    .res       (lane_y)
  );

  jdsp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (b_fire),
    .op     (op_b_r),
    .button (btn_b_r),
    .lane_x (lane_x),
    .lane_y (lane_y),
    .cfg    (cfg_r),
    .res    (res)
  );

  assign out_ch.valid   = out_valid_r;
  assign out_ch.drive_x = res.drive_x;
  assign out_ch.drive_y = res.drive_y;
  assign out_ch.x_width = res.x_width;
  assign out_ch.y_width = res.y_width;
  assign out_ch.frozen  = res.frozen;

`ifndef ASSERT_OFF
  // Frozen flag only moves on a sample beat loaded into the merge stage
  a_frozen_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.frozen != $past(out_ch.frozen)) |-> $past(b_fire && (op_b_r == OP_SAMPLE)))
    else $error("frozen changed without a sample beat");

  // Sample beats never move the pulse pins
  a_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(b_fire && (op_b_r == OP_SAMPLE)) |->
      (out_ch.drive_x == $past(out_ch.drive_x)) && (out_ch.drive_y == $past(out_ch.drive_y)))
    else $error("pin level changed on a sample beat");

  // Full pipeline with a stalled receiver takes no new beat
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_a_r && v_b_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("beat accepted into a full pipeline");
`endif

endmodule

FILE: dv/tb_joystick_dual_servo_pulse_generator.sv
// Self-checking bench for the joystick dual servo pulse generator.
// Drives tick and sample beats under several register settings and checks each result beat.
// Depends on jdsp_pkg, jdsp_if and the joystick_dual_servo_pulse_generator RTL.
`timescale 1ns / 1ps

module tb_joystick_dual_servo_pulse_generator;
  import jdsp_pkg::*;

  localparam int unsigned STEP_DIV  = 4608;
  localparam int          HOLD_LONG = 300;

  typedef struct {
    logic                   op;
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic                   button;
  } joy_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  jdsp_in_if  in_ch ();
  jdsp_out_if out_ch ();

  joystick_dual_servo_pulse_generator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Stimulus and prediction stores
  joy_beat_t joy_beats[$];
  res_t      servo_state_q[$];
  int        beats_queued  = 0;
  int        results_seen  = 0;
  int        mismatches    = 0;
  logic      beat_taken    = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      hold_req      = 1'b0;
  logic      hold_done     = 1'b0;
  int        hold_left     = 0;
  logic      gen_btn       = 1'b0;

  // Mirror of the block's registers and servo state
  cfg_t       regs;
  logic       pending_first, x_done, y_done;
  logic [7:0] edge_cnt, slot_tick_cnt;
  logic [4:0] slot_no;
  logic       pin_x, pin_y;
  logic [7:0] wid_x, wid_y;
  logic       btn_held, release_timing;
  logic [15:0] sub_sec;
  logic [7:0] secs;
  logic       frozen_st;

  function automatic void servo_reset();
    regs.dead_low         = DEAD_LOW_RST;
    regs.dead_high        = DEAD_HIGH_RST;
    regs.width_min        = WIDTH_MIN_RST;
    regs.width_max        = WIDTH_MAX_RST;
    regs.slot_last        = SLOT_LAST_RST;
    regs.slots_per_frame  = SLOTS_RST;
    regs.ticks_per_second = TICKS_SEC_RST;
    regs.hold_seconds     = HOLD_SEC_RST;
    pending_first  = 1'b1;
    x_done         = 1'b0;
    y_done         = 1'b0;
    edge_cnt       = '0;
    slot_tick_cnt  = '0;
    slot_no        = '0;
    pin_x          = 1'b0;
    pin_y          = 1'b0;
    wid_x          = WIDTH_RST;
    wid_y          = WIDTH_RST;
    btn_held       = 1'b0;
    release_timing = 1'b0;
    sub_sec        = '0;
    secs           = '0;
    frozen_st      = 1'b0;
  endfunction

  function automatic void mirror_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      CFG_DEAD_LOW:  regs.dead_low         = d[9:0];
      CFG_DEAD_HIGH: regs.dead_high        = d[9:0];
      CFG_WIDTH_MIN: regs.width_min        = d[7:0];
      CFG_WIDTH_MAX: regs.width_max        = d[7:0];
      CFG_SLOT_LAST: regs.slot_last        = d[7:0];
      CFG_SLOTS:     regs.slots_per_frame  = d[4:0];
      CFG_TICKS_SEC: regs.ticks_per_second = d[15:0];
      CFG_HOLD_SEC:  regs.hold_seconds     = d[7:0];
      default: ;
    endcase
  endfunction

  // Joystick nudge of one width; step is taken from the distance to mid-scale
  function automatic logic [7:0] nudge_width(logic [7:0] cur, logic [SAMPLE_BITS-1:0] s);
    int unsigned mid, sv, offs, lo, hi, half, step, w;
    mid  = 1 << (SAMPLE_BITS - 1);
    sv   = 32'(s);
    lo   = 32'(regs.width_min);
    hi   = 32'(regs.width_max);
    offs = (sv >= mid) ? sv - mid : mid - sv;
    half = (hi >= lo) ? (hi - lo) / 2 : 0;
    step = offs * half / STEP_DIV;
    w    = 32'(cur);
    if (sv < int'(regs.dead_low)) begin
      if (w + step <= hi) w = w + step;
    end else if (sv > int'(regs.dead_high)) begin
      if (step <= w && w - step >= lo) w = w - step;
    end
    return w[7:0];
  endfunction

  // Advance the servo state by one beat and return the output it leaves
  function automatic res_t servo_step(joy_beat_t b);
    res_t r;
    if (b.op == OP_TICK) begin
      if (pending_first) begin
        pin_x = 1'b1;
        pin_y = 1'b1;
        pending_first = 1'b0;
      end
      if (edge_cnt >= wid_x && !x_done) begin
        pin_x  = 1'b0;
        x_done = 1'b1;
      end
      if (edge_cnt >= wid_y && !y_done) begin
        pin_y  = 1'b0;
        y_done = 1'b1;
      end
      edge_cnt = edge_cnt + 8'd1;
      if (slot_tick_cnt >= regs.slot_last) begin
        slot_tick_cnt = '0;
        slot_no = slot_no + 5'd1;
      end else begin
        slot_tick_cnt = slot_tick_cnt + 8'd1;
      end
      // frame restart
      if (slot_no >= regs.slots_per_frame) begin
        slot_no       = '0;
        pin_x         = 1'b1;
        pin_y         = 1'b1;
        x_done        = 1'b0;
        y_done        = 1'b0;
        edge_cnt      = '0;
        slot_tick_cnt = '0;
      end
      // hold timer after a button release
      if (release_timing) begin
        sub_sec = sub_sec + 16'd1;
        if (sub_sec >= regs.ticks_per_second) begin
          sub_sec = '0;
          if (secs < SECONDS_MAX) secs = secs + 8'd1;
        end
      end
    end else begin
      if (b.button && !btn_held && !release_timing) btn_held = 1'b1;
      if (!b.button && btn_held) begin
        btn_held       = 1'b0;
        sub_sec        = '0;
        secs           = '0;
        release_timing = 1'b1;
      end
      if (!frozen_st) begin
        wid_x = nudge_width(wid_x, b.x);
        wid_y = nudge_width(wid_y, b.y);
      end
      if (release_timing && (frozen_st || secs >= regs.hold_seconds)) begin
        frozen_st      = !frozen_st;
        release_timing = 1'b0;
      end
    end
    r.drive_x = pin_x;
    r.drive_y = pin_y;
    r.x_width = wid_x;
    r.y_width = wid_y;
    r.frozen  = frozen_st;
    return r;
  endfunction

  function automatic cfg_t make_setting(int dl, int dh, int wmin, int wmax,
                                        int sl, int spf, int tps, int hs);
    cfg_t s;
    s.dead_low         = dl[9:0];
    s.dead_high        = dh[9:0];
    s.width_min        = wmin[7:0];
    s.width_max        = wmax[7:0];
    s.slot_last        = sl[7:0];
    s.slots_per_frame  = spf[4:0];
    s.ticks_per_second = tps[15:0];
    s.hold_seconds     = hs[7:0];
    return s;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input acceptance: predict on every accepted beat
  always @(posedge clk) begin : beat_accept
    joy_beat_t b;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      b.op     = in_ch.op;
      b.x      = in_ch.x_sample;
      b.y      = in_ch.y_sample;
      b.button = in_ch.button;
      servo_state_q.push_back(servo_step(b));
      beat_taken <= 1'b1;
    end else begin
      beat_taken <= 1'b0;
    end
  end

  // Beat driver: holds a beat until taken, idles at random between beats
  always @(negedge clk) begin : beat_driver
    joy_beat_t nb;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !beat_taken) begin
      // offered beat not yet taken, keep it
    end else if (joy_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      nb = joy_beats.pop_front();
      in_ch.valid    <= 1'b1;
      in_ch.op       <= nb.op;
      in_ch.x_sample <= nb.x;
      in_ch.y_sample <= nb.y;
      in_ch.button   <= nb.button;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result sink: random stalls plus one long hold-off on request
  always @(negedge clk) begin : result_sink
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LONG;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen = results_seen + 1;
      got.drive_x = out_ch.drive_x;
      got.drive_y = out_ch.drive_y;
      got.x_width = out_ch.x_width;
      got.y_width = out_ch.y_width;
      got.frozen  = out_ch.frozen;
      if (servo_state_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("ERROR: result beat %0d arrived with no prediction pending", results_seen);
      end else begin
        want = servo_state_q.pop_front();
        if (got.drive_x !== want.drive_x || got.drive_y !== want.drive_y ||
            got.x_width !== want.x_width || got.y_width !== want.y_width ||
            got.frozen !== want.frozen) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("ERROR: beat %0d exp pins %b%b w %0d/%0d frz %b, got pins %b%b w %0d/%0d frz %b",
                     results_seen, want.drive_x, want.drive_y, want.x_width, want.y_width,
                     want.frozen, got.drive_x, got.drive_y, got.x_width, got.y_width,
                     got.frozen);
        end
      end
    end
  end

  task automatic queue_beat(logic op, logic [SAMPLE_BITS-1:0] x,
                            logic [SAMPLE_BITS-1:0] y, logic btn);
    joy_beat_t b;
    b.op     = op;
    b.x      = x;
    b.y      = y;
    b.button = btn;
    joy_beats.push_back(b);
    beats_queued = beats_queued + 1;
  endtask

  // Readings biased toward the rails, mid-scale and the dead band edges
  function automatic logic [SAMPLE_BITS-1:0] pick_reading();
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
      3: v = SAMPLE_BITS'(regs.dead_low - 10'd1);
      4: v = SAMPLE_BITS'(regs.dead_high + 10'd1);
      5: v = SAMPLE_BITS'(regs.dead_low);
      default: v = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endcase
    return v;
  endfunction

  task automatic queue_tick();
    queue_beat(OP_TICK, SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)),
               SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)),
               1'($urandom_range(0, 1)));
  endtask

  // Tick bursts (some long enough for hold timing) and sample bursts with button edges
  task automatic gen_traffic(int n);
    int made, kind, len;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = (kind < 4) ? $urandom_range(150, 300) : $urandom_range(1, 24);
        for (int i = 0; i < len; i++) queue_tick();
      end else begin
        if ($urandom_range(0, 99) < 35) gen_btn = !gen_btn;
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) queue_beat(OP_SAMPLE, pick_reading(), pick_reading(), gen_btn);
      end
      made = made + len;
    end
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    mirror_reg(idx, d);
  endtask

  task automatic program_setting(cfg_t s);
    program_reg(CFG_DEAD_LOW,  CFG_W'(s.dead_low));
    program_reg(CFG_DEAD_HIGH, CFG_W'(s.dead_high));
    program_reg(CFG_WIDTH_MIN, CFG_W'(s.width_min));
    program_reg(CFG_WIDTH_MAX, CFG_W'(s.width_max));
    program_reg(CFG_SLOT_LAST, CFG_W'(s.slot_last));
    program_reg(CFG_SLOTS,     CFG_W'(s.slots_per_frame));
    program_reg(CFG_TICKS_SEC, s.ticks_per_second);
    program_reg(CFG_HOLD_SEC,  CFG_W'(s.hold_seconds));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Every queued beat has returned its result, then an idle margin
  task automatic wait_drained();
    while (results_seen < beats_queued) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_TICK;
    in_ch.x_sample = '0;
    in_ch.y_sample = '0;
    in_ch.button   = 1'b0;
    out_ch.ready   = 1'b0;
    servo_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Defaults: first-frame rise, rails, dead band edges, press and release
    send_idle_pct = 24;
    recv_idle_pct = 57;
    queue_beat(OP_TICK, '1, '1, 1'b1);
    queue_beat(OP_TICK, '0, '0, 1'b0);
    queue_beat(OP_SAMPLE, '0, '1, 1'b0);
    queue_beat(OP_SAMPLE, '1, '0, 1'b0);
    queue_beat(OP_SAMPLE, 10'd512, 10'd512, 1'b0);
    queue_beat(OP_SAMPLE, 10'd499, 10'd525, 1'b0);
    queue_beat(OP_SAMPLE, 10'd500, 10'd524, 1'b0);
    queue_beat(OP_SAMPLE, 10'd525, 10'd499, 1'b0);
    queue_beat(OP_SAMPLE, 10'd512, 10'd512, 1'b1);
    queue_beat(OP_SAMPLE, '0, '0, 1'b1);
    queue_beat(OP_SAMPLE, '1, '1, 1'b0);
    queue_beat(OP_TICK, '1, '0, 1'b1);
    queue_beat(OP_SAMPLE, '0, '1, 1'b1);
    queue_beat(OP_SAMPLE, '0, '1, 1'b0);
    for (int i = 0; i < 60; i++) queue_tick();
    gen_traffic(120);
    wait_drained();

    // Overlapping dead band, widest limits, longest frame and hold
    program_setting(make_setting(1023, 0, 0, 255, 255, 31, 65535, 255));
    gen_traffic(190);
    wait_drained();

    // Inverted limits, frame ends every tick, seconds every tick (saturates)
    send_idle_pct = 57;
    recv_idle_pct = 24;
    program_setting(make_setting(400, 600, 100, 20, 0, 0, 0, 255));
    gen_traffic(190);
    wait_drained();

    // Short frames so pins fall, quick hold timing
    program_setting(make_setting(480, 540, 2, 30, 3, 6, 2, 3));
    gen_traffic(190);
    wait_drained();

    // No idling; long receiver hold-off fills the pipeline
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_setting(make_setting(512, 512, 10, 200, 1, 1, 1, 1));
    gen_traffic(190);
    hold_req = 1'b1;
    wait_drained();

    // No dead band moves, freeze right at release
    program_setting(make_setting(0, 1023, 255, 255, 255, 1, 65535, 0));
    gen_traffic(190);
    wait_drained();

    // Raw random register data (upper bits exercise masking), then short hold timing
    program_reg(CFG_DEAD_LOW,  CFG_W'($urandom_range(0, 65535)));
    program_reg(CFG_DEAD_HIGH, CFG_W'($urandom_range(0, 65535)));
    program_reg(CFG_WIDTH_MIN, CFG_W'($urandom_range(0, 65535)));
    program_reg(CFG_WIDTH_MAX, CFG_W'($urandom_range(0, 65535)));
    program_reg(CFG_SLOT_LAST, CFG_W'($urandom_range(0, 65535)));
    program_reg(CFG_SLOTS,     CFG_W'($urandom_range(0, 65535)));
    program_reg(CFG_TICKS_SEC, CFG_W'($urandom_range(0, 3)));
    program_reg(CFG_HOLD_SEC,  CFG_W'($urandom_range(0, 4)));
    @(negedge clk);
    cfg_we = 1'b0;
    gen_traffic(190);
    wait_drained();
    repeat (10) @(negedge clk);

    if (mismatches == 0 && servo_state_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
